@@ rtl/gsa_pkg.sv @@
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants for the GSA sentence parser.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int NUM_SLOTS   = 12;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // field positions within a sentence
  localparam logic [POS_W-1:0] POS_SEL       = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIX       = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SAT_FIRST = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PDOP      = POS_W'(3 + NUM_SLOTS);
  localparam logic [POS_W-1:0] POS_HDOP      = POS_W'(4 + NUM_SLOTS);
  localparam logic [POS_W-1:0] POS_VDOP      = POS_W'(5 + NUM_SLOTS);

  localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(NUM_SLOTS - 1);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [19:0] FIX_LIMIT = 20'd15;
  localparam logic [19:0] SAT_LIMIT = 20'd1023;
  localparam logic [19:0] DOP_LIMIT = 20'd65535;

  typedef enum logic {
    CMD_CHAR  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    JOB_SENTENCE = 1'b0,
    JOB_QUERY    = 1'b1
  } job_kind_t;

  typedef logic [NUM_SLOTS-1:0][9:0] slots_t;

  // one queued request: a snapshot of the stores plus what to report
  typedef struct packed {
    job_kind_t   kind;
    logic        hit;
    logic [7:0]  sel;
    logic [3:0]  fix;
    logic [15:0] pdop;
    logic [15:0] hdop;
    logic [15:0] vdop;
    slots_t      slots;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/gsa_in_if.sv @@
// ----------------------------------------------------------------------------
// gsa_in_if
// Input channel: sentence characters and satellite queries.
// ----------------------------------------------------------------------------
interface gsa_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_byte;
  logic       first_of_sentence;
  logic       end_of_sentence;
  logic [9:0] sat_query;

  modport source (output valid, command, char_byte, first_of_sentence, end_of_sentence,
                  sat_query, input ready);
  modport sink (input valid, command, char_byte, first_of_sentence, end_of_sentence,
                sat_query, output ready);
endinterface

@@ rtl/gsa_out_if.sv @@
// ----------------------------------------------------------------------------
// gsa_out_if
// Result channel: slot reports and query answers.
// ----------------------------------------------------------------------------
interface gsa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  selection_char;
  logic [3:0]  fix_mode;
  logic [3:0]  slot_index;
  logic [9:0]  sat_number;
  logic [15:0] pdop;
  logic [15:0] hdop;
  logic [15:0] vdop;
  logic        query_hit;
  logic        last_of_run;

  modport source (output valid, selection_char, fix_mode, slot_index, sat_number, pdop,
                  hdop, vdop, query_hit, last_of_run, input ready);
  modport sink (input valid, selection_char, fix_mode, slot_index, sat_number, pdop,
                hdop, vdop, query_hit, last_of_run, output ready);
endinterface

@@ rtl/gsa_front.sv @@
// ----------------------------------------------------------------------------
// gsa_front
// Character parser: splits fields, accumulates numbers, updates the stores and
// queues a snapshot request on sentence end or query.
// ----------------------------------------------------------------------------
module gsa_front import gsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gsa_in_if.sink    in_ch,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             empty_r, empty_nxt;
  logic             stopped_r, stopped_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic             point_r, point_nxt;
  logic [1:0]       frac_r, frac_nxt;
  logic             done_r, done_nxt;
  logic [7:0]       sel_r, sel_nxt;
  logic [3:0]       fix_r, fix_nxt;
  slots_t           slots_r, slots_nxt;
  logic [15:0]      pdop_r, pdop_nxt;
  logic [15:0]      hdop_r, hdop_nxt;
  logic [15:0]      vdop_r, vdop_nxt;

  logic accept;
  logic hit;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0]  c;
    logic        digit;
    logic        is_dop;
    logic [19:0] d;
    logic [19:0] acc10;
    logic [19:0] v;
    c      = in_ch.char_byte;
    digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = 20'(c[3:0]);
    v      = '0;
    acc10  = '0;
    is_dop = 1'b0;

    pos_nxt     = pos_r;
    empty_nxt   = empty_r;
    stopped_nxt = stopped_r;
    acc_nxt     = acc_r;
    point_nxt   = point_r;
    frac_nxt    = frac_r;
    done_nxt    = done_r;
    sel_nxt     = sel_r;
    fix_nxt     = fix_r;
    slots_nxt   = slots_r;
    pdop_nxt    = pdop_r;
    hdop_nxt    = hdop_r;
    vdop_nxt    = vdop_r;

    if (accept && in_ch.command == CMD_CHAR) begin
      if (in_ch.first_of_sentence) begin
        pos_nxt     = '0;
        done_nxt    = 1'b0;
        empty_nxt   = 1'b1;
        stopped_nxt = 1'b0;
        acc_nxt     = '0;
        point_nxt   = 1'b0;
        frac_nxt    = '0;
      end
      is_dop = (pos_nxt >= POS_PDOP) && (pos_nxt <= POS_VDOP);
      acc10  = ({4'b0, acc_nxt} << 3) + ({4'b0, acc_nxt} << 1);
      if (!done_nxt) begin
        if (c == CH_COMMA || (c == CH_STAR && pos_nxt == POS_VDOP)) begin
          // close the field and commit its value
          if (pos_nxt == POS_SEL) begin
            if (empty_nxt) sel_nxt = CH_COMMA;
          end else if (pos_nxt == POS_FIX) begin
            fix_nxt = acc_nxt[3:0];
          end else if (is_dop) begin
            if (!empty_nxt) begin
              if (pos_nxt == POS_PDOP) pdop_nxt = acc_nxt;
              else if (pos_nxt == POS_HDOP) hdop_nxt = acc_nxt;
              else vdop_nxt = acc_nxt;
            end
          end
          for (int k = 0; k < NUM_SLOTS; k++) begin
            if (pos_nxt == POS_SAT_FIRST + POS_W'(k)) slots_nxt[k] = acc_nxt[9:0];
          end
          if (pos_nxt >= POS_VDOP) done_nxt = 1'b1;
          else pos_nxt = pos_nxt + POS_W'(1);
          empty_nxt   = 1'b1;
          stopped_nxt = 1'b0;
          acc_nxt     = '0;
          point_nxt   = 1'b0;
          frac_nxt    = '0;
        end else begin
          if (pos_nxt == POS_SEL && empty_nxt) sel_nxt = c;
          empty_nxt = 1'b0;
          if (pos_nxt >= POS_FIX && !stopped_nxt) begin
            if (is_dop) begin
              if (digit) begin
                if (!point_nxt) v = acc10 + d * 20'd100;
                else if (frac_nxt == 2'd0) v = {4'b0, acc_nxt} + d * 20'd10;
                else if (frac_nxt == 2'd1) v = {4'b0, acc_nxt} + d;
                else v = {4'b0, acc_nxt};
                if (point_nxt && frac_nxt != 2'd2) frac_nxt = frac_nxt + 2'd1;
                if (v > DOP_LIMIT) v = DOP_LIMIT;
                acc_nxt = v[15:0];
              end else if (c == CH_DOT && !point_nxt) begin
                point_nxt = 1'b1;
              end else begin
                stopped_nxt = 1'b1;
              end
            end else begin
              if (digit) begin
                v = acc10 + d;
                if (pos_nxt == POS_FIX) begin
                  if (v > FIX_LIMIT) v = FIX_LIMIT;
                end else begin
                  if (v > SAT_LIMIT) v = SAT_LIMIT;
                end
                acc_nxt = v[15:0];
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (slots_r[k] == in_ch.sat_query) hit = 1'b1;
    end
  end

  // a query leaves the stores alone, so the next values serve both cases
  assign push = accept && (in_ch.command == CMD_QUERY || in_ch.end_of_sentence);
  always_comb begin
    push_job.kind  = (in_ch.command == CMD_QUERY) ? JOB_QUERY : JOB_SENTENCE;
    push_job.hit   = hit;
    push_job.sel   = sel_nxt;
    push_job.fix   = fix_nxt;
    push_job.pdop  = pdop_nxt;
    push_job.hdop  = hdop_nxt;
    push_job.vdop  = vdop_nxt;
    push_job.slots = slots_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      empty_r   <= 1'b1;
      stopped_r <= 1'b0;
      acc_r     <= '0;
      point_r   <= 1'b0;
      frac_r    <= '0;
      done_r    <= 1'b0;
      sel_r     <= '0;
      fix_r     <= '0;
      slots_r   <= '0;
      pdop_r    <= '0;
      hdop_r    <= '0;
      vdop_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      empty_r   <= empty_nxt;
      stopped_r <= stopped_nxt;
      acc_r     <= acc_nxt;
      point_r   <= point_nxt;
      frac_r    <= frac_nxt;
      done_r    <= done_nxt;
      sel_r     <= sel_nxt;
      fix_r     <= fix_nxt;
      slots_r   <= slots_nxt;
      pdop_r    <= pdop_nxt;
      hdop_r    <= hdop_nxt;
      vdop_r    <= vdop_nxt;
    end
  end

endmodule

@@ rtl/gsa_fifo.sv @@
// ----------------------------------------------------------------------------
// gsa_fifo
// Short request queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module gsa_fifo import gsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t status
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + (QPTR_W+1)'(1);
    else if (pop && !push) count_nxt = count_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full || pop) else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("request popped from an empty queue");
`endif

endmodule

@@ rtl/gsa_back.sv @@
// ----------------------------------------------------------------------------
// gsa_back
// Result sequencer: walks the slots of a queued sentence request, or answers a
// query, into the output register.
// ----------------------------------------------------------------------------
module gsa_back import gsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head_job,
  input  q_status_t q_status,
  output logic      pop,
  gsa_out_if.source out_ch
);

  logic [SLOT_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            sel_r;
  logic [3:0]            fix_r;
  logic [3:0]            slot_r;
  logic [9:0]            sat_r;
  logic [15:0]           pdop_r, hdop_r, vdop_r;
  logic                  hit_r, last_r;
  logic                  load;
  logic                  is_query;

  assign is_query = (head_job.kind == JOB_QUERY);
  assign load     = (!out_valid_r || out_ch.ready) && !q_status.empty;
  // drop the request once its final result is loaded
  assign pop      = load && (is_query || cnt_r == LAST_SLOT);

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!is_query) cnt_nxt = (cnt_r == LAST_SLOT) ? '0 : cnt_r + SLOT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel_r  <= head_job.sel;
      fix_r  <= head_job.fix;
      pdop_r <= head_job.pdop;
      hdop_r <= head_job.hdop;
      vdop_r <= head_job.vdop;
      if (is_query) begin
        slot_r <= '0;
        sat_r  <= '0;
        hit_r  <= head_job.hit;
        last_r <= 1'b1;
      end else begin
        slot_r <= 4'(cnt_r);
        sat_r  <= head_job.slots[cnt_r];
        hit_r  <= 1'b0;
        last_r <= (cnt_r == LAST_SLOT);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.selection_char = sel_r;
  assign out_ch.fix_mode       = fix_r;
  assign out_ch.slot_index     = slot_r;
  assign out_ch.sat_number     = sat_r;
  assign out_ch.pdop           = pdop_r;
  assign out_ch.hdop           = hdop_r;
  assign out_ch.vdop           = vdop_r;
  assign out_ch.query_hit      = hit_r;
  assign out_ch.last_of_run    = last_r;

`ifndef SYNTHESIS
  a_mid_run_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> !q_status.empty && !is_query)
    else $error("slot walk in progress without a sentence request at the head");
  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> last_r && slot_r == '0 && sat_r == '0)
    else $error("query answer is not a single bare result");
`endif

endmodule

@@ rtl/nmea_gsa_sentence_parser.sv @@
// ----------------------------------------------------------------------------
// nmea_gsa_sentence_parser
// GSA sentence parser: characters in, twelve slot reports per sentence end,
// one answer per satellite query.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake        Payload
// in_ch    in   valid / ready    command, char_byte, first/end flags, sat_query
// out_ch   out  valid / ready    selection, fix, slot, sat, DOPs, hit, last
//
// Accepts one character per cycle while in_ch.ready holds; the parser updates its
// stores in that cycle. A sentence end yields NUM_SLOTS results, a query one. The
// sequencer emits one result per cycle while out_ch.ready holds; a two-deep
// request queue sits between. in_ch.ready drops only while that queue is full.
// Reset is synchronous, active low, and clears all stores to zero.
// ----------------------------------------------------------------------------
module nmea_gsa_sentence_parser import gsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gsa_in_if.sink    in_ch,
  gsa_out_if.source out_ch
);

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_status;

  gsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  gsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  gsa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ verif/gsa_report_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsa_report_checker
// Watches both channels of the GSA parser and tracks the parser state from
// the accepted requests. It predicts every result, and each accepted result is
// compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module gsa_report_checker import gsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gsa_in_if    in_ch,
  gsa_out_if   out_ch,
  output int   mismatch_count,
  output int   reports_pending
);

  typedef struct packed {
    logic [7:0]  sel;
    logic [3:0]  fix;
    logic [3:0]  slot;
    logic [9:0]  sat;
    logic [15:0] pdop;
    logic [15:0] hdop;
    logic [15:0] vdop;
    logic        hit;
    logic        last;
  } report_t;

  report_t expected_reports[$];
  int      error_total = 0;

  // parser state
  logic [POS_W-1:0] field_pos;
  logic             field_blank;
  logic             digits_stopped;
  logic [15:0]      acc;
  logic             point_seen;
  logic [1:0]       frac_digits;
  logic             line_done;
  logic [7:0]       sel_store;
  logic [3:0]       fix_store;
  logic [9:0]       slot_store [NUM_SLOTS];
  logic [15:0]      pdop_store;
  logic [15:0]      hdop_store;
  logic [15:0]      vdop_store;

  function automatic void clear_field();
    field_blank    = 1'b1;
    digits_stopped = 1'b0;
    acc            = '0;
    point_seen     = 1'b0;
    frac_digits    = '0;
  endfunction

  function automatic void reset_stores();
    field_pos  = '0;
    line_done  = 1'b0;
    clear_field();
    sel_store  = '0;
    fix_store  = '0;
    foreach (slot_store[k]) slot_store[k] = '0;
    pdop_store = '0;
    hdop_store = '0;
    vdop_store = '0;
  endfunction

  // store the field that a terminator just closed
  function automatic void close_field();
    if (field_pos == POS_SEL) begin
      if (field_blank) sel_store = CH_COMMA;
    end else if (field_pos == POS_FIX) begin
      fix_store = acc[3:0];
    end else if (field_pos >= POS_SAT_FIRST && field_pos < POS_PDOP) begin
      slot_store[field_pos - POS_SAT_FIRST] = acc[9:0];
    end else if (!field_blank) begin
      // an empty DOP field keeps the old value
      if (field_pos == POS_PDOP) pdop_store = acc;
      else if (field_pos == POS_HDOP) hdop_store = acc;
      else if (field_pos == POS_VDOP) vdop_store = acc;
    end
    if (field_pos >= POS_VDOP) line_done = 1'b1;
    else field_pos = field_pos + 1'b1;
    clear_field();
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic        is_digit;
    logic [31:0] d;
    logic [31:0] v;
    logic [31:0] limit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = 32'(c - CH_ZERO);
    v        = 32'(acc);
    if (c == CH_COMMA || (c == CH_STAR && field_pos == POS_VDOP)) begin
      close_field();
      return;
    end
    if (field_pos == POS_SEL && field_blank) sel_store = c;
    field_blank = 1'b0;
    if (field_pos < POS_FIX || digits_stopped) return;
    if (field_pos >= POS_PDOP) begin
      // hundredths: integer digits scale by 100, keep two fraction digits
      if (is_digit) begin
        if (!point_seen) v = v * 10 + d * 100;
        else if (frac_digits == 2'd0) v = v + d * 10;
        else if (frac_digits == 2'd1) v = v + d;
        if (point_seen && frac_digits < 2'd2) frac_digits = frac_digits + 1'b1;
        acc = (v > 32'(DOP_LIMIT)) ? 16'hFFFF : v[15:0];
      end else if (c == CH_DOT && !point_seen) begin
        point_seen = 1'b1;
      end else begin
        digits_stopped = 1'b1;
      end
    end else begin
      limit = (field_pos == POS_FIX) ? 32'(FIX_LIMIT) : 32'(SAT_LIMIT);
      if (is_digit) begin
        v   = v * 10 + d;
        acc = (v > limit) ? limit[15:0] : v[15:0];
      end else begin
        digits_stopped = 1'b1;
      end
    end
  endfunction

  function automatic report_t make_report(input logic [3:0] slot, input logic [9:0] sat,
                                          input logic hit, input logic last);
    return '{sel: sel_store, fix: fix_store, slot: slot, sat: sat, pdop: pdop_store,
             hdop: hdop_store, vdop: vdop_store, hit: hit, last: last};
  endfunction

  function automatic void take_request();
    logic hit;
    hit = 1'b0;
    if (in_ch.command == CMD_QUERY) begin
      foreach (slot_store[k]) if (slot_store[k] == in_ch.sat_query) hit = 1'b1;
      expected_reports.push_back(make_report(4'd0, 10'd0, hit, 1'b1));
      return;
    end
    if (in_ch.first_of_sentence) begin
      field_pos = '0;
      line_done = 1'b0;
      clear_field();
    end
    if (!line_done) parse_char(in_ch.char_byte);
    if (in_ch.end_of_sentence) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        expected_reports.push_back(make_report(4'(k), slot_store[k], 1'b0,
                                               k == NUM_SLOTS - 1));
      end
    end
  endfunction

  function automatic void show(input string label, input report_t r);
    $display("  %s sel %h fix %0d slot %0d sat %0d pdop %0d hdop %0d vdop %0d hit %b last %b",
             label, r.sel, r.fix, r.slot, r.sat, r.pdop, r.hdop, r.vdop, r.hit, r.last);
  endfunction

  function automatic void check_report();
    report_t got;
    report_t want;
    got = '{sel: out_ch.selection_char, fix: out_ch.fix_mode, slot: out_ch.slot_index,
            sat: out_ch.sat_number, pdop: out_ch.pdop, hdop: out_ch.hdop,
            vdop: out_ch.vdop, hit: out_ch.query_hit, last: out_ch.last_of_run};
    if (expected_reports.size() == 0) begin
      error_total++;
      if (error_total <= 10) begin
        $display("%0t: result with nothing predicted", $time);
        show("actual  ", got);
      end
      return;
    end
    want = expected_reports.pop_front();
    if (got !== want) begin
      error_total++;
      if (error_total <= 10) begin
        $display("%0t: result mismatch", $time);
        show("expected", want);
        show("actual  ", got);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_stores();
      expected_reports.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) take_request();
      if (out_ch.valid && out_ch.ready) check_report();
    end
    mismatch_count  <= error_total;
    reports_pending <= expected_reports.size();
  end

endmodule

@@ verif/nmea_gsa_sentence_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_gsa_sentence_parser_test
// Feeds the GSA parser with directed and random sentences, broken sentences,
// noise characters and satellite queries, with random gaps and result stalls.
// The report checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module nmea_gsa_sentence_parser_test;
  import gsa_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       gaps_on;
  int         mismatch_count;
  int         reports_pending;
  int         items_sent = 0;
  logic [7:0] line_q[$];

  gsa_in_if  in_ch ();
  gsa_out_if out_ch ();

  nmea_gsa_sentence_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gsa_report_checker i_report_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: stall at random while gaps are enabled
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && !(gaps_on && $urandom_range(99) < 18);
    end
  end

  task automatic push_request(input cmd_t cmd, input logic [7:0] c, input logic first,
                              input logic last, input logic [9:0] q);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.command           <= cmd;
    in_ch.char_byte         <= c;
    in_ch.first_of_sentence <= first;
    in_ch.end_of_sentence   <= last;
    in_ch.sat_query         <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic first, input logic last);
    push_request(CMD_CHAR, c, first, last, 10'($urandom_range(1023)));
  endtask

  task automatic send_query(input logic [9:0] q);
    push_request(CMD_QUERY, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), q);
  endtask

  // half of the picks are small numbers so that queries hit stored satellites
  function automatic logic [9:0] pick_sat_number();
    return $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(40));
  endfunction

  // hold valid low and wait until every predicted result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  task automatic send_line(input logic with_first, input logic with_end, input logic mix);
    for (int i = 0; i < line_q.size(); i++) begin
      if (mix && $urandom_range(24) == 0) send_query(pick_sat_number());
      send_char(line_q[i], with_first && i == 0, with_end && i == line_q.size() - 1);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_COMMA);
    return c;
  endfunction

  task automatic add_count_field(input int typical_max);
    case ($urandom_range(9))
      0, 1: ;
      2, 3, 4, 5: add_text($sformatf("%0d", $urandom_range(1, typical_max)));
      6: add_text($sformatf("%0d%0d", $urandom_range(9), $urandom_range(99999)));
      7: begin
        line_q.push_back($urandom_range(1) ? 8'h2D : 8'h20);
        add_text($sformatf("%0d", $urandom_range(9)));
      end
      8: begin
        add_text($sformatf("%0d", $urandom_range(1, 99)));
        line_q.push_back(junk_char());
        add_text("7");
      end
      default: line_q.push_back(junk_char());
    endcase
  endtask

  task automatic add_dop_field();
    case ($urandom_range(11))
      0, 1: ;
      2, 3, 4, 5: add_text($sformatf("%0d.%02d", $urandom_range(30), $urandom_range(99)));
      6: add_text($sformatf("%0d", $urandom_range(700)));
      7: add_text($sformatf(".%0d", $urandom_range(9)));
      8: add_text($sformatf("%0d.%0d", $urandom_range(9), $urandom_range(100, 99999)));
      9: add_text($sformatf("%0d.%0d", $urandom_range(600, 99999), $urandom_range(99)));
      10: add_text($sformatf("%0d.%0d.%0d", $urandom_range(9), $urandom_range(9),
                             $urandom_range(9)));
      default: begin
        line_q.push_back(junk_char());
        add_text("1.5");
      end
    endcase
  endtask

  task automatic build_sentence();
    int cut;
    line_q.delete();
    case ($urandom_range(3))
      0: add_text("$GPGSA");
      1: add_text("$GNGSA");
      2: ;
      default: line_q.push_back(junk_char());
    endcase
    add_text(",");
    case ($urandom_range(4))
      0: ;
      1: add_text("A");
      2: add_text("M");
      3: line_q.push_back(junk_char());
      default: begin
        line_q.push_back(junk_char());
        line_q.push_back(junk_char());
      end
    endcase
    add_text(",");
    add_count_field(3);
    add_text(",");
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if ($urandom_range(2) != 0) add_count_field(40);
      add_text(",");
    end
    add_dop_field();
    add_text(",");
    add_dop_field();
    add_text(",");
    add_dop_field();
    line_q.push_back($urandom_range(3) != 0 ? CH_STAR : CH_COMMA);
    // checksum and trailing characters, ignored once VDOP has closed
    repeat ($urandom_range(3)) line_q.push_back($urandom_range(4) != 0 ? junk_char() : CH_COMMA);
    // sometimes cut the sentence short, leaving a field open
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, line_q.size());
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
  endtask

  initial begin
    int pick;
    bit paused;
    paused = 1'b0;
    rst_n                   <= 1'b0;
    gaps_on                 <= 1'b1;
    in_ch.valid             <= 1'b0;
    in_ch.command           <= CMD_CHAR;
    in_ch.char_byte         <= '0;
    in_ch.first_of_sentence <= 1'b0;
    in_ch.end_of_sentence   <= 1'b0;
    in_ch.sat_query         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty slots match number 0 right after reset
    send_query(10'd0);
    send_query(10'd1023);
    // empty selection, saturated fix and satellite, sign stops the digits
    line_q.delete();
    add_text("$,,99,2000,-5,");
    send_line(1'b1, 1'b1, 1'b0);
    send_query(10'd1023);
    // one-character sentence: fields never reached keep their values
    send_char(CH_STAR, 1'b1, 1'b1);
    drain();

    while (items_sent < 330) begin
      gaps_on <= !(items_sent >= 130 && items_sent < 230);
      if (!paused && items_sent >= 260) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 68) begin
        build_sentence();
        send_line($urandom_range(11) != 0, $urandom_range(15) != 0, 1'b1);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 3)) send_query(pick_sat_number());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(255)), $urandom_range(7) == 0, $urandom_range(7) == 0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
